### src/aliquot_sum_classifier_assert.svh
// Assertion macros for the aliquot sum classifier datapath.
`ifndef ALIQUOT_SUM_CLASSIFIER_ASSERT_SVH
`define ALIQUOT_SUM_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASC_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`define ASC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define ASC_ASSERT_NOW(label, pre, post)
`define ASC_ASSERT_NEXT(label, pre, post)
`endif
`endif

### src/asc_pkg.sv
// Shared types, codes and microcode table of the aliquot sum classifier.
package asc_pkg;

	localparam int NUMBER_BITS_DEF = 16;
	localparam int SUM_OUT_W       = 18;
	localparam int CLASS_W         = 2;
	localparam int COUNT_W         = 32;
	localparam int OUT_DATA_W      = 120;
	localparam logic [SUM_OUT_W-1:0] SUM_MAX = 18'h3FFFF;

	typedef enum logic [CLASS_W-1:0] {
		CLS_DEFICIENT = 2'd0,
		CLS_PERFECT   = 2'd1,
		CLS_ABUNDANT  = 2'd2
	} class_t;

	typedef logic [2:0] step_t;
	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_FIX  = 3'd1;
	localparam step_t STEP_TEST = 3'd2;
	localparam step_t STEP_NEXT = 3'd3;
	localparam step_t STEP_EMIT = 3'd4;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_FIX  = 3'd1,
		OP_ACC  = 3'd2,
		OP_STEP = 3'd3,
		OP_EMIT = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CND_ALWAYS   = 3'd0,
		CND_IN_VALID = 3'd1,
		CND_R_NEG    = 3'd2,
		CND_D_GT_Q   = 3'd3,
		CND_OUT_BUSY = 3'd4
	} cond_t;

	// One control word: on a true condition go to tgt_hit, otherwise tgt_miss.
	typedef struct packed {
		logic  accept;
		op_t   op;
		cond_t cond;
		step_t tgt_hit;
		step_t tgt_miss;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic hit;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic r_neg;
		logic d_gt_q;
		logic out_busy;
	} status_t;

	function automatic uword_t ucode(step_t pc);
		uword_t w;
		unique case (pc)
			STEP_IDLE: w = '{1'b1, OP_LOAD, CND_IN_VALID, STEP_FIX,  STEP_IDLE};
			STEP_FIX:  w = '{1'b0, OP_FIX,  CND_R_NEG,    STEP_FIX,  STEP_TEST};
			STEP_TEST: w = '{1'b0, OP_ACC,  CND_D_GT_Q,   STEP_EMIT, STEP_NEXT};
			STEP_NEXT: w = '{1'b0, OP_STEP, CND_ALWAYS,   STEP_FIX,  STEP_FIX};
			STEP_EMIT: w = '{1'b0, OP_EMIT, CND_OUT_BUSY, STEP_EMIT, STEP_IDLE};
			default:   w = '{1'b0, OP_STEP, CND_ALWAYS,   STEP_IDLE, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/aliquot_sum_classifier.sv
// Top level of the aliquot sum classifier: deficient, perfect or abundant.
// Run time per item is set by the remainder fix-up step: one quotient decrement per cycle
// while the divisor walks from 1 to sqrt(n), and three microcode steps per candidate.
// A new item is taken while the last result waits; the next result is held until that one is taken.
// Reset (arst_n low, asynchronous): step counter to idle, counters cleared, no result held.
module aliquot_sum_classifier #(
	parameter int NUMBER_BITS = asc_pkg::NUMBER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input item stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [((NUMBER_BITS+7)/8)*8-1:0] s_axis_tdata,  // number, zero padding
	// Result item stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [asc_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // divisor_sum, number_class,
	                                                       // deficient_count, perfect_count,
	                                                       // abundant_count, zero padding
);

	localparam int PAD_W = asc_pkg::OUT_DATA_W - asc_pkg::SUM_OUT_W - asc_pkg::CLASS_W
		- 3 * asc_pkg::COUNT_W;

	asc_pkg::ctrl_t   ctrl;
	asc_pkg::status_t status;

	logic [asc_pkg::SUM_OUT_W-1:0] divisor_sum;
	logic [asc_pkg::CLASS_W-1:0]   number_class;
	logic [asc_pkg::COUNT_W-1:0]   deficient_count;
	logic [asc_pkg::COUNT_W-1:0]   perfect_count;
	logic [asc_pkg::COUNT_W-1:0]   abundant_count;

	// The microcode program: idle/load, remainder fix-up, divisor test and accumulate,
	// advance to the next candidate, then emit once the candidate passes sqrt(n).
	asc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.accept (s_axis_tready)
	);

	// Datapath: walks quotient and remainder of n by d incrementally, so no divider is
	// needed; sums divisor pairs, classes the item and holds the result until taken.
	asc_datapath #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.status          (status),
		.in_valid        (s_axis_tvalid),
		.number          (s_axis_tdata[NUMBER_BITS-1:0]),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.divisor_sum     (divisor_sum),
		.number_class    (number_class),
		.deficient_count (deficient_count),
		.perfect_count   (perfect_count),
		.abundant_count  (abundant_count)
	);

	// Pack fields lowest first.
	assign m_axis_tdata = {{PAD_W{1'b0}}, abundant_count, perfect_count, deficient_count,
		number_class, divisor_sum};

endmodule

### src/asc_sequencer.sv
// Step counter, microcode lookup and branch logic.
module asc_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  asc_pkg::status_t status,
	output asc_pkg::ctrl_t   ctrl,
	output logic             accept
);

	asc_pkg::step_t  pc_q;
	asc_pkg::uword_t uw;
	logic            hit;

	assign uw = asc_pkg::ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			asc_pkg::CND_ALWAYS:   hit = 1'b1;
			asc_pkg::CND_IN_VALID: hit = status.in_valid;
			asc_pkg::CND_R_NEG:    hit = status.r_neg;
			asc_pkg::CND_D_GT_Q:   hit = status.d_gt_q;
			asc_pkg::CND_OUT_BUSY: hit = status.out_busy;
			default:               hit = 1'b0;
		endcase
	end

	assign ctrl.op  = uw.op;
	assign ctrl.hit = hit;
	assign accept   = uw.accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= asc_pkg::STEP_IDLE;
		end else begin
			pc_q <= hit ? uw.tgt_hit : uw.tgt_miss;
		end
	end

endmodule

### src/asc_datapath.sv
// Quotient/remainder walk, divisor accumulator, classifier and result register.
`include "aliquot_sum_classifier_assert.svh"
module asc_datapath #(
	parameter int NUMBER_BITS = asc_pkg::NUMBER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  asc_pkg::ctrl_t                      ctrl,
	output asc_pkg::status_t                    status,
	input  logic                                in_valid,
	input  logic [NUMBER_BITS-1:0]              number,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [asc_pkg::SUM_OUT_W-1:0]       divisor_sum,
	output logic [asc_pkg::CLASS_W-1:0]         number_class,
	output logic [asc_pkg::COUNT_W-1:0]         deficient_count,
	output logic [asc_pkg::COUNT_W-1:0]         perfect_count,
	output logic [asc_pkg::COUNT_W-1:0]         abundant_count
);

	localparam int NB    = NUMBER_BITS;
	localparam int RW    = NB + 2;
	localparam int SW    = NB + 3;
	localparam int CMP_W = (SW > asc_pkg::SUM_OUT_W) ? SW : asc_pkg::SUM_OUT_W;
	localparam int CW    = asc_pkg::COUNT_W;

	logic [NB-1:0] n_q;
	logic [NB-1:0] d_q;
	logic [NB-1:0] q_q;
	logic [RW-1:0] r_q;
	logic [SW-1:0] total_q;

	logic                          out_valid_q;
	logic [asc_pkg::SUM_OUT_W-1:0] sum_q;
	asc_pkg::class_t               class_q;
	logic [CW-1:0]                 deficient_q;
	logic [CW-1:0]                 perfect_q;
	logic [CW-1:0]                 abundant_q;

	logic                          emit;
	logic [SW-1:0]                 pair_sum;
	logic [SW-1:0]                 aliquot;
	logic [CMP_W-1:0]              aliquot_wide;
	logic [asc_pkg::SUM_OUT_W-1:0] sum_sat;
	asc_pkg::class_t               cls;

	assign status.in_valid = in_valid;
	assign status.r_neg    = r_q[RW-1];
	assign status.d_gt_q   = d_q > q_q;
	assign status.out_busy = out_valid_q && !out_ready;

	assign emit = (ctrl.op == asc_pkg::OP_EMIT) && !ctrl.hit;

	// Both members of a divisor pair; the square root counts once.
	assign pair_sum = SW'(d_q) + ((q_q != d_q) ? SW'(q_q) : '0);

	// Divisor total includes n itself, so drop it here.
	assign aliquot      = total_q - SW'(n_q);
	assign aliquot_wide = CMP_W'(aliquot);
	assign sum_sat      = (aliquot_wide > CMP_W'(asc_pkg::SUM_MAX)) ? asc_pkg::SUM_MAX
		: aliquot_wide[asc_pkg::SUM_OUT_W-1:0];

	always_comb begin
		priority if (aliquot < SW'(n_q)) begin
			cls = asc_pkg::CLS_DEFICIENT;
		end else if (aliquot == SW'(n_q)) begin
			cls = asc_pkg::CLS_PERFECT;
		end else begin
			cls = asc_pkg::CLS_ABUNDANT;
		end
	end

	// Invariant: n = q * d + r, with r held in two's complement.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			asc_pkg::OP_LOAD: begin
				if (ctrl.hit) begin
					n_q     <= number;
					d_q     <= NB'(1);
					q_q     <= number;
					r_q     <= '0;
					total_q <= '0;
				end
			end
			asc_pkg::OP_FIX: begin
				if (ctrl.hit) begin
					r_q <= r_q + RW'(d_q);
					q_q <= q_q - NB'(1);
				end
			end
			asc_pkg::OP_ACC: begin
				if (!ctrl.hit && (r_q == '0)) begin
					total_q <= total_q + pair_sum;
				end
			end
			asc_pkg::OP_STEP: begin
				d_q <= d_q + NB'(1);
				r_q <= r_q - RW'(q_q);
			end
			asc_pkg::OP_EMIT: begin
				if (emit) begin
					sum_q   <= sum_sat;
					class_q <= cls;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			deficient_q <= '0;
			perfect_q   <= '0;
			abundant_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				unique case (cls)
					asc_pkg::CLS_DEFICIENT: begin
						if (deficient_q != '1) deficient_q <= deficient_q + CW'(1);
					end
					asc_pkg::CLS_PERFECT: begin
						if (perfect_q != '1) perfect_q <= perfect_q + CW'(1);
					end
					asc_pkg::CLS_ABUNDANT: begin
						if (abundant_q != '1) abundant_q <= abundant_q + CW'(1);
					end
					default: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign divisor_sum     = sum_q;
	assign number_class    = class_q;
	assign deficient_count = deficient_q;
	assign perfect_count   = perfect_q;
	assign abundant_count  = abundant_q;

	`ASC_ASSERT_NOW(a_rem_in_range, ctrl.op == asc_pkg::OP_ACC, !r_q[RW-1] && (r_q < RW'(d_q)))
	`ASC_ASSERT_NOW(a_fix_quotient, (ctrl.op == asc_pkg::OP_FIX) && ctrl.hit, q_q != '0)
	`ASC_ASSERT_NEXT(a_counts_hold, out_valid_q && !out_ready, $stable(deficient_q) && $stable(perfect_q) && $stable(abundant_q))

endmodule

### bench/tb.sv
// Testbench for the aliquot sum classifier: directed and random numbers checked against a predictor.
module tb;

	localparam int NUM_W        = ((asc_pkg::NUMBER_BITS_DEF + 7) / 8) * 8;
	localparam int HOLD_CYCLES  = 3000;
	localparam int SETTLE_TAIL  = 64;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int PRINT_CAP    = 40;

	// One predicted result item, field by field.
	typedef struct {
		logic [asc_pkg::SUM_OUT_W-1:0] divisor_sum;
		asc_pkg::class_t               number_class;
		logic [asc_pkg::COUNT_W-1:0]   deficient_count;
		logic [asc_pkg::COUNT_W-1:0]   perfect_count;
		logic [asc_pkg::COUNT_W-1:0]   abundant_count;
	} classification_t;

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           s_axis_tvalid  = 1'b0;
	logic                           s_axis_tready;
	logic [NUM_W-1:0]               s_axis_tdata   = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready  = 1'b0;
	logic [asc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	classification_t             classifications_due [$];
	logic [asc_pkg::COUNT_W-1:0] deficient_seen = '0;
	logic [asc_pkg::COUNT_W-1:0] perfect_seen   = '0;
	logic [asc_pkg::COUNT_W-1:0] abundant_seen  = '0;
	int                          mismatch_count = 0;
	int                          numbers_sent   = 0;
	int                          cycle_count    = 0;
	bit                          calm           = 1'b0;
	int                          hold_token     = 0;
	int                          hold_seen      = 0;

	aliquot_sum_classifier uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sum of the proper divisors, by pairing d with n/d up to sqrt(n).
	function automatic longint unsigned proper_divisor_total(input longint unsigned n);
		longint unsigned total;
		total = 0;
		if (n == 0)
			return 0;
		for (longint unsigned d = 1; d * d <= n; d++) begin
			if (n % d == 0) begin
				total += d;
				if (n / d != d)
					total += n / d;
			end
		end
		return total - n;
	endfunction

	function automatic logic [asc_pkg::COUNT_W-1:0] bump_count(
			input logic [asc_pkg::COUNT_W-1:0] c);
		return (c == '1) ? c : c + asc_pkg::COUNT_W'(1);
	endfunction

	// Advance the class counters and queue the result this number must produce.
	task automatic classify_number(input logic [NUM_W-1:0] number);
		longint unsigned n;
		longint unsigned s;
		classification_t r;
		n = number & ((64'd1 << asc_pkg::NUMBER_BITS_DEF) - 1);
		s = proper_divisor_total(n);
		if (s < n) begin
			r.number_class = asc_pkg::CLS_DEFICIENT;
			deficient_seen = bump_count(deficient_seen);
		end else if (s == n) begin
			r.number_class = asc_pkg::CLS_PERFECT;
			perfect_seen = bump_count(perfect_seen);
		end else begin
			r.number_class = asc_pkg::CLS_ABUNDANT;
			abundant_seen = bump_count(abundant_seen);
		end
		r.divisor_sum     = (s > asc_pkg::SUM_MAX) ? asc_pkg::SUM_MAX
			: s[asc_pkg::SUM_OUT_W-1:0];
		r.deficient_count = deficient_seen;
		r.perfect_count   = perfect_seen;
		r.abundant_count  = abundant_seen;
		classifications_due.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Offer one number, hold it until accepted; idle a random burst first unless calm.
	task automatic send_number(input logic [NUM_W-1:0] number);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= number;
		do @(posedge clk); while (!s_axis_tready);
		classify_number(number);
		numbers_sent++;
	endtask

	// Mostly small numbers keep the run short; perfect numbers show up now and then.
	function automatic logic [NUM_W-1:0] pick_number(input bit allow_large);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (allow_large)
			return NUM_W'($urandom_range(0, 65535));
		if (roll < 5) begin
			case ($urandom_range(0, 3))
				0: return 16'd6;
				1: return 16'd28;
				2: return 16'd496;
				default: return 16'd8128;
			endcase
		end
		if (roll < 80)
			return NUM_W'($urandom_range(0, 255));
		return NUM_W'($urandom_range(256, 2047));
	endfunction

	// Check each accepted result against the oldest prediction.
	always @(posedge clk) begin
		classification_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (classifications_due.size() == 0) begin
				report_mismatch("unexpected result item",
					m_axis_tdata[asc_pkg::SUM_OUT_W-1:0], 0);
			end else begin
				want = classifications_due.pop_front();
				if (m_axis_tdata[17:0] !== want.divisor_sum)
					report_mismatch("divisor_sum", m_axis_tdata[17:0], want.divisor_sum);
				if (m_axis_tdata[19:18] !== want.number_class)
					report_mismatch("number_class", m_axis_tdata[19:18], want.number_class);
				if (m_axis_tdata[51:20] !== want.deficient_count)
					report_mismatch("deficient_count", m_axis_tdata[51:20], want.deficient_count);
				if (m_axis_tdata[83:52] !== want.perfect_count)
					report_mismatch("perfect_count", m_axis_tdata[83:52], want.perfect_count);
				if (m_axis_tdata[115:84] !== want.abundant_count)
					report_mismatch("abundant_count", m_axis_tdata[115:84], want.abundant_count);
			end
		end
	end

	// Receiver side: count down a long hold-off on request, else idle in random bursts.
	always @(posedge clk) begin
		int stall_left;
		if (hold_token != hold_seen) begin
			hold_seen  <= hold_token;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				classifications_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Extremes, the perfect numbers, one and zero, and the slowest inputs.
	task automatic test_directed_values();
		logic [NUM_W-1:0] picks [16];
		picks = '{16'd1, 16'd0, 16'd2, 16'd6, 16'd28, 16'd496, 16'd8128, 16'd12,
			16'd945, 16'd16, 16'd251, 16'd255, 16'd4095, 16'd55440, 16'd32768, 16'd65535};
		foreach (picks[i])
			send_number(picks[i]);
		send_number(16'd1);
	endtask

	task automatic test_random_numbers(input int count);
		for (int i = 0; i < count; i++)
			send_number(pick_number(i % 25 == 12));
	endtask

	// Stall the receiver for a long stretch while numbers keep coming, so the input backs up.
	task automatic test_backpressure();
		hold_token <= hold_token + 1;
		for (int i = 0; i < 10; i++)
			send_number(NUM_W'($urandom_range(0, 40)));
	endtask

	// Drop valid and wait until every result is out, then resume.
	task automatic test_pause_until_drained();
		s_axis_tvalid <= 1'b0;
		while (classifications_due.size() != 0) @(posedge clk);
		for (int i = 0; i < 5; i++)
			send_number(pick_number(1'b0));
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_steady_stream(input int count);
		calm = 1'b1;
		for (int i = 0; i < count; i++)
			send_number(pick_number(1'b0));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_random_numbers(60);
		test_backpressure();
		test_pause_until_drained();
		test_steady_stream(30);
		s_axis_tvalid <= 1'b0;
		while (classifications_due.size() != 0) @(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
		if (classifications_due.size() != 0)
			report_mismatch("results never delivered", 0, classifications_due.size());
		$display("Classified %0d numbers: %0d deficient, %0d perfect, %0d abundant",
			numbers_sent, deficient_seen, perfect_seen, abundant_seen);
		$display("Ran extremes, random traffic with idling, a long output hold-off and a drain pause");
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
